[sv/lfia_pkg.sv]
package lfia_pkg;

   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   localparam logic [WORD_W-1:0] ALL_FREE = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_ALLOC    = 2'd0,
      KIND_FREE     = 2'd1,
      KIND_REGISTER = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_BAD_ID  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN
   } state_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[sv/lowest_free_id_allocator_top.sv]
// lowest-free id allocator over DEPTH ids, id 0 is never handed out
// input channel: req_kind / req_given_id, taken at a clock edge where start is
//   high and busy is low (allocate, free id, register id as used)
// result channel: one result per request, rsp_granted_id / rsp_status shown for
//   exactly one cycle while rsp_valid is high; the receiver cannot stall it
// results: bad id, exhausted allocate and unknown kind answer in the cycle after
//   the transfer; free, register and allocate first read and write back the id's
//   bitmap word, and the lowest-free search may go on to read further words
// the search reads one 32-bit word of the bitmap ram per cycle through its single
//   read port
// busy stays high after a bitmap transfer until the result is registered (the quick
//   answers leave it low), so a new request can be taken in the cycle the result is shown
// reset: after reset the bitmap ram is initialized one word per cycle, with busy
//   high; then every id but 0 is free and the next id to hand out is 1
module lowest_free_id_allocator_top #(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [9:0]  req_given_id,
   output logic        rsp_valid,
   output logic [9:0]  rsp_granted_id,
   output logic [1:0]  rsp_status
);

   localparam int ID_W      = $clog2(DEPTH + 1);
   localparam int PW        = (ID_W < 6) ? 6 : ID_W;
   localparam int WORDS     = (DEPTH + lfia_pkg::WORD_W - 1) / lfia_pkg::WORD_W;
   localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LAST_BITS = DEPTH - (WORDS - 1) * lfia_pkg::WORD_W;
   localparam logic [lfia_pkg::WORD_W-1:0] LAST_MASK =
      lfia_pkg::ALL_FREE >> (lfia_pkg::WORD_W - LAST_BITS);

   lfia_pkg::state_type state_ff, state_in;
   lfia_pkg::kind_type  kind_ff, kind_in;
   logic [PW-1:0]       id_ff, id_in;
   logic [PW-1:0]       next_id_ff, next_id_in;
   logic [WORD_AW-1:0]  scan_word_ff, scan_word_in;
   logic [WORD_AW-1:0]  clr_addr_ff, clr_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [9:0]          rsp_granted_ff, rsp_granted_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   logic                         wr_en;
   logic [WORD_AW-1:0]           wr_addr;
   logic [lfia_pkg::WORD_W-1:0]  wr_data;
   logic [WORD_AW-1:0]           rd_addr;
   logic [lfia_pkg::WORD_W-1:0]  rd_data;

   logic [PW-1:0]                given_id;
   logic                         bad_id;
   logic [WORD_AW-1:0]           id_word;
   logic [lfia_pkg::BIT_W-1:0]   id_bit;
   logic [lfia_pkg::WORD_W-1:0]  new_word;
   logic [lfia_pkg::WORD_W-1:0]  above;
   logic [lfia_pkg::WORD_W-1:0]  clr_word;

   lfia_map #(
      .WORDS(WORDS),
      .AW   (WORD_AW)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfia_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         next_id_ff   <= PW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      id_ff          <= id_in;
      scan_word_ff   <= scan_word_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign given_id = PW'(req_given_id);
   assign bad_id   = (req_given_id == 10'd0) || (32'(req_given_id) >= DEPTH);
   assign id_word  = WORD_AW'(id_ff >> lfia_pkg::BIT_W);
   assign id_bit   = id_ff[lfia_pkg::BIT_W-1:0];
   assign new_word = (kind_ff == lfia_pkg::KIND_FREE)
                   ? (rd_data | (lfia_pkg::WORD_W'(1) << id_bit))
                   : (rd_data & ~(lfia_pkg::WORD_W'(1) << id_bit));
   // free ids strictly above the one just taken
   assign above    = new_word & ((lfia_pkg::ALL_FREE << id_bit) << 1);
   assign clr_word = ((clr_addr_ff == WORD_AW'(WORDS - 1)) ? LAST_MASK : lfia_pkg::ALL_FREE)
                   & ((clr_addr_ff == '0) ? ~lfia_pkg::WORD_W'(1) : lfia_pkg::ALL_FREE);

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      id_in          = id_ff;
      next_id_in     = next_id_ff;
      scan_word_in   = scan_word_ff;
      clr_addr_in    = clr_addr_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = '0;
      rsp_status_in  = lfia_pkg::STATUS_OK;
      wr_en          = 1'b0;
      wr_addr        = id_word;
      wr_data        = new_word;
      rd_addr        = id_word;

      unique case (state_ff)
         lfia_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = clr_word;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == WORD_AW'(WORDS - 1)) begin
               state_in = lfia_pkg::ST_IDLE;
            end
         end

         lfia_pkg::ST_IDLE: begin
            if (start) begin
               kind_in = lfia_pkg::kind_type'(req_kind);
               unique case (lfia_pkg::kind_type'(req_kind))
                  lfia_pkg::KIND_ALLOC: begin
                     if (next_id_ff == PW'(DEPTH)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lfia_pkg::STATUS_NO_FREE;
                     end else begin
                        id_in    = next_id_ff;
                        rd_addr  = WORD_AW'(next_id_ff >> lfia_pkg::BIT_W);
                        state_in = lfia_pkg::ST_MODIFY;
                     end
                  end
                  lfia_pkg::KIND_FREE, lfia_pkg::KIND_REGISTER: begin
                     if (bad_id) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lfia_pkg::STATUS_BAD_ID;
                     end else begin
                        id_in    = given_id;
                        rd_addr  = WORD_AW'(given_id >> lfia_pkg::BIT_W);
                        state_in = lfia_pkg::ST_MODIFY;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         lfia_pkg::ST_MODIFY: begin
            wr_en = 1'b1;
            if (kind_ff == lfia_pkg::KIND_ALLOC) begin
               rsp_granted_in = 10'(id_ff);
            end
            if (kind_ff == lfia_pkg::KIND_FREE ||
                (kind_ff == lfia_pkg::KIND_REGISTER && next_id_ff != id_ff)) begin
               if (kind_ff == lfia_pkg::KIND_FREE && id_ff < next_id_ff) begin
                  next_id_in = id_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = lfia_pkg::ST_IDLE;
            end else if (above != '0) begin
               next_id_in   = PW'({id_word, lfia_pkg::lowest_set(above)});
               rsp_valid_in = 1'b1;
               state_in     = lfia_pkg::ST_IDLE;
            end else if (id_word == WORD_AW'(WORDS - 1)) begin
               next_id_in   = PW'(DEPTH);
               rsp_valid_in = 1'b1;
               state_in     = lfia_pkg::ST_IDLE;
            end else begin
               // read of the following word overlaps the write-back
               scan_word_in = id_word + 1'b1;
               rd_addr      = id_word + 1'b1;
               state_in     = lfia_pkg::ST_SCAN;
            end
         end

         lfia_pkg::ST_SCAN: begin
            if (kind_ff == lfia_pkg::KIND_ALLOC) begin
               rsp_granted_in = 10'(id_ff);
            end
            rd_addr = scan_word_ff + 1'b1;
            if (rd_data != '0) begin
               next_id_in   = PW'({scan_word_ff, lfia_pkg::lowest_set(rd_data)});
               rsp_valid_in = 1'b1;
               state_in     = lfia_pkg::ST_IDLE;
            end else if (scan_word_ff == WORD_AW'(WORDS - 1)) begin
               next_id_in   = PW'(DEPTH);
               rsp_valid_in = 1'b1;
               state_in     = lfia_pkg::ST_IDLE;
            end else begin
               scan_word_in = scan_word_ff + 1'b1;
            end
         end

         default: begin
            state_in = lfia_pkg::ST_IDLE;
         end
      endcase

      if (!rsp_valid_in) begin
         rsp_granted_in = '0;
      end
   end

   assign busy           = (state_ff != lfia_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_granted_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

[sv/lfia_map.sv]
module lfia_map #(
   parameter int WORDS = 32,
   parameter int AW    = 5
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [lfia_pkg::WORD_W-1:0]   wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [lfia_pkg::WORD_W-1:0]   rd_data
);

   logic [lfia_pkg::WORD_W-1:0] mem [WORDS];
   logic [lfia_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lfia_checker.sv]
module lfia_checker #(
   parameter int DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [9:0]  req_given_id,
   input  logic        rsp_valid,
   input  logic [9:0]  rsp_granted_id,
   input  logic [1:0]  rsp_status
);

   logic accept;
   assign accept = start && !busy;

   // unknown kind answers at once with an empty ok
   assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == lfia_pkg::KIND_NONE
      |=> rsp_valid && rsp_status == lfia_pkg::STATUS_OK && rsp_granted_id == 10'd0)
      else $error("unknown kind not answered with empty ok");

   // id zero is always rejected on free or register
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == lfia_pkg::KIND_FREE || req_kind == lfia_pkg::KIND_REGISTER)
      && req_given_id == 10'd0
      |=> rsp_valid && rsp_status == lfia_pkg::STATUS_BAD_ID)
      else $error("id zero not rejected");

   // a valid free goes through the bitmap update and holds off new transfers
   assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == lfia_pkg::KIND_FREE && req_given_id != 10'd0
      && 32'(req_given_id) < DEPTH
      |=> busy && !rsp_valid)
      else $error("valid free answered without bitmap update");

   // failed results never carry an id
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lfia_pkg::STATUS_OK |-> rsp_granted_id == 10'd0)
      else $error("failed result carries an id");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == lfia_pkg::STATUS_OK
      || rsp_status == lfia_pkg::STATUS_NO_FREE || rsp_status == lfia_pkg::STATUS_BAD_ID)
      else $error("undefined status code");

endmodule

bind lowest_free_id_allocator_top lfia_checker #(.DEPTH(DEPTH)) u_lfia_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_kind      (req_kind),
   .req_given_id  (req_given_id),
   .rsp_valid     (rsp_valid),
   .rsp_granted_id(rsp_granted_id),
   .rsp_status    (rsp_status)
);

[tb/lowest_free_id_allocator_top_tb.sv]
module lowest_free_id_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 1024;
   localparam int SMALL_IDS = 96;

   typedef struct {
      lfia_pkg::kind_type kind;
      logic [9:0]         given_id;
   } id_request_type;

   typedef struct {
      logic [9:0]           granted_id;
      lfia_pkg::status_type status;
   } id_grant_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_kind = '0;
   logic [9:0] req_given_id = '0;
   logic       rsp_valid;
   logic [9:0] rsp_granted_id;
   logic [1:0] rsp_status;

   id_request_type request_queue[$];
   id_grant_type   grant_expect[$];
   id_request_type next_req;
   id_grant_type   oldest_grant;
   int             error_count = 0;
   int             transfer_count = 0;

   // shadow of the block: 1 = free
   bit          shadow_free[DEPTH];
   int unsigned shadow_next_id;

   lowest_free_id_allocator_top #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_given_id(req_given_id),
      .rsp_valid(rsp_valid),
      .rsp_granted_id(rsp_granted_id),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int unsigned free_above(input int unsigned id);
      for (int unsigned i = id + 1; i < DEPTH; i++) begin
         if (shadow_free[i]) begin
            return i;
         end
      end
      return DEPTH;
   endfunction

   function automatic void predict_grant(input lfia_pkg::kind_type kind,
                                         input logic [9:0] given_id);
      id_grant_type g;
      int unsigned  id;
      id = 32'(given_id);
      g.granted_id = '0;
      g.status = lfia_pkg::STATUS_OK;
      unique case (kind)
         lfia_pkg::KIND_ALLOC: begin
            if (shadow_next_id >= DEPTH) begin
               g.status = lfia_pkg::STATUS_NO_FREE;
            end else begin
               g.granted_id = shadow_next_id[9:0];
               shadow_free[shadow_next_id] = 1'b0;
               shadow_next_id = free_above(shadow_next_id);
            end
         end
         lfia_pkg::KIND_FREE, lfia_pkg::KIND_REGISTER: begin
            if (id == 0 || id >= DEPTH) begin
               g.status = lfia_pkg::STATUS_BAD_ID;
            end else if (kind == lfia_pkg::KIND_FREE) begin
               shadow_free[id] = 1'b1;
               if (id < shadow_next_id) begin
                  shadow_next_id = id;
               end
            end else begin
               shadow_free[id] = 1'b0;
               if (shadow_next_id == id) begin
                  shadow_next_id = free_above(id);
               end
            end
         end
         default: ;
      endcase
      grant_expect = {grant_expect, g};
   endfunction

   function automatic void add_request(input lfia_pkg::kind_type kind,
                                       input logic [9:0] given_id);
      id_request_type r;
      r.kind = kind;
      r.given_id = given_id;
      request_queue = {request_queue, r};
   endfunction

   // mostly allocate / free / register on low ids, some full-range and broken ones
   function automatic void add_random_request();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         add_request(lfia_pkg::KIND_ALLOC, 10'($urandom));
      end else if (roll < 68) begin
         add_request(lfia_pkg::KIND_FREE, 10'($urandom_range(1, SMALL_IDS)));
      end else if (roll < 78) begin
         add_request(lfia_pkg::KIND_FREE, 10'($urandom_range(0, DEPTH - 1)));
      end else if (roll < 86) begin
         add_request(lfia_pkg::KIND_REGISTER, 10'($urandom_range(1, SMALL_IDS)));
      end else if (roll < 92) begin
         add_request(lfia_pkg::KIND_REGISTER, 10'($urandom_range(0, DEPTH - 1)));
      end else if (roll < 96) begin
         add_request(($urandom_range(0, 1) != 0) ? lfia_pkg::KIND_FREE
                                                 : lfia_pkg::KIND_REGISTER, 10'd0);
      end else begin
         add_request(lfia_pkg::KIND_NONE, 10'($urandom));
      end
   endfunction

   // no idling in the middle stretch of the run
   function automatic bit sender_idles();
      if (transfer_count >= 150 && transfer_count < 450) begin
         return 1'b0;
      end
      return $urandom_range(0, 99) < 6;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_grant(lfia_pkg::kind_type'(req_kind), req_given_id);
            transfer_count++;
         end
         if (!start || !busy) begin
            if (request_queue.size() != 0 && !sender_idles()) begin
               next_req = request_queue.pop_front();
               req_kind <= next_req.kind;
               req_given_id <= next_req.given_id;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (grant_expect.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: id %0d status %0d",
                                      rsp_granted_id, rsp_status));
         end else begin
            oldest_grant = grant_expect.pop_front();
            if (rsp_granted_id !== oldest_grant.granted_id) begin
               report_mismatch($sformatf("granted_id %0d, expected %0d",
                                         rsp_granted_id, oldest_grant.granted_id));
            end
            if (rsp_status !== oldest_grant.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, oldest_grant.status));
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         shadow_free[i] = (i != 0);
      end
      shadow_next_id = 1;

      // directed part
      add_request(lfia_pkg::KIND_ALLOC, 10'd0);
      add_request(lfia_pkg::KIND_ALLOC, 10'h3FF);
      add_request(lfia_pkg::KIND_ALLOC, 10'h155);
      add_request(lfia_pkg::KIND_FREE, 10'd2);
      add_request(lfia_pkg::KIND_ALLOC, 10'h2AA);
      add_request(lfia_pkg::KIND_REGISTER, 10'd4);      // pointer sits on 4
      add_request(lfia_pkg::KIND_REGISTER, 10'd6);      // away from pointer
      add_request(lfia_pkg::KIND_REGISTER, 10'd6);      // already used
      add_request(lfia_pkg::KIND_ALLOC, 10'd0);
      add_request(lfia_pkg::KIND_ALLOC, 10'd0);         // skips the registered id
      add_request(lfia_pkg::KIND_FREE, 10'd0);
      add_request(lfia_pkg::KIND_REGISTER, 10'd0);
      add_request(lfia_pkg::KIND_NONE, 10'h3FF);
      add_request(lfia_pkg::KIND_NONE, 10'd0);
      add_request(lfia_pkg::KIND_FREE, 10'h3FF);        // double free
      add_request(lfia_pkg::KIND_REGISTER, 10'h3FF);
      add_request(lfia_pkg::KIND_FREE, 10'h3FF);
      add_request(lfia_pkg::KIND_FREE, 10'd1);
      add_request(lfia_pkg::KIND_ALLOC, 10'd0);
      add_request(lfia_pkg::KIND_REGISTER, 10'd512);
      add_request(lfia_pkg::KIND_FREE, 10'd512);

      for (int i = 0; i < 200; i++) begin
         add_random_request();
      end
      // run of allocations that walks the pointer across several words
      for (int i = 0; i < 180; i++) begin
         add_request(lfia_pkg::KIND_ALLOC, 10'($urandom));
      end
      for (int i = 0; i < 200; i++) begin
         add_random_request();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || start || grant_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (DEPTH / 32 + 8) @(posedge clock);

      if (grant_expect.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", grant_expect.size()));
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[lowest_free_id_allocator_top.f]
sv/lfia_pkg.sv
sv/lfia_map.sv
sv/lowest_free_id_allocator_top.sv
sv/lfia_checker.sv
tb/lowest_free_id_allocator_top_tb.sv
